// ===== src/seven_segment_bank_transposer_defines.svh =====
// Assertion macros shared by the checker of the seven-segment bank transposer.
`ifndef SEVEN_SEGMENT_BANK_TRANSPOSER_DEFINES_SVH
`define SEVEN_SEGMENT_BANK_TRANSPOSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ssbt_pkg.sv =====
// Package of the seven-segment bank transposer: word types, glyph table, point logic.
package ssbt_pkg;

  localparam int NumDigits = 8;
  localparam int DigitW    = 5;
  localparam int RowIdxW   = 3;
  localparam logic [7:0] PointBit = 8'h80;
  localparam logic [7:0] BlankGlyph = 8'h00;

  // Segments a..g in bits 0..6.
  localparam logic [7:0] Glyph [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    logic              bank;
    logic [DigitW-1:0] digit_0;
    logic [DigitW-1:0] digit_1;
    logic [DigitW-1:0] digit_2;
    logic [DigitW-1:0] digit_3;
    logic [DigitW-1:0] digit_4;
    logic [DigitW-1:0] digit_5;
    logic [DigitW-1:0] digit_6;
    logic [DigitW-1:0] digit_7;
    logic [3:0]        point_position;
    logic              point_flash;
  } ssbt_in_t;

  typedef struct packed {
    logic [3:0] grid_address;
    logic [7:0] segment_byte;
    logic       last_write;
  } ssbt_out_t;

  typedef logic [7:0] pattern_t;

  // Decimal point of digit idx. Bank 0 uses positions 1..7 directly plus the flash
  // point on digit 3; bank 1 uses positions 1..8 offset by one.
  function automatic logic point_lit(logic bank, logic [3:0] pos, logic flash,
                                     logic [RowIdxW-1:0] idx);
    logic lit;
    if (!bank) begin
      lit = (flash && (idx == RowIdxW'(3))) ||
            ((pos >= 4'd1) && (pos <= 4'd7) && (pos == {1'b0, idx}));
    end else begin
      lit = (pos >= 4'd1) && (pos <= 4'd8) && (pos == ({1'b0, idx} + 4'd1));
    end
    return lit;
  endfunction

endpackage

// ===== src/ssbt_lane.sv =====
// One digit lane: hex glyph lookup plus decimal point.
module ssbt_lane
  import ssbt_pkg::*;
(
  input  logic [DigitW-1:0] digit_i,
  input  logic              point_i,
  output pattern_t          pattern_o
);

  pattern_t glyph;

  always_comb begin
    // Codes 16 and above show blank.
    if (digit_i[DigitW-1]) begin
      glyph = BlankGlyph;
    end else begin
      glyph = Glyph[digit_i[3:0]];
    end
    pattern_o = point_i ? (glyph | PointBit) : glyph;
  end

endmodule

// ===== src/ssbt_merge.sv =====
// Merging stage: transposes the lane patterns and sends one segment row per cycle.
module ssbt_merge
  import ssbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  logic      bank_i,
  input  pattern_t  pattern_i [NumDigits],
  output logic      busy_o,
  output logic      valid_o,
  output ssbt_out_t result_o
);

  logic [7:0]         rows_q [NumDigits];
  logic [7:0]         rows_d [NumDigits];
  logic               bank_q;
  logic               active_q;
  logic [RowIdxW-1:0] row_q;
  logic               last_row;

  // Row j collects segment j of every digit.
  always_comb begin
    for (int j = 0; j < NumDigits; j++) begin
      for (int i = 0; i < NumDigits; i++) begin
        rows_d[j][i] = pattern_i[i][j];
      end
    end
  end

  assign last_row = (row_q == RowIdxW'(NumDigits - 1));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rows_q <= rows_d;
      bank_q <= bank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
    end else if (load_i) begin
      active_q <= 1'b1;
      row_q    <= '0;
    end else if (active_q) begin
      if (last_row) begin
        active_q <= 1'b0;
      end
      row_q <= row_q + RowIdxW'(1);
    end
  end

  // A new word may load during the final row, so banks follow with no gap.
  assign busy_o                = active_q && !last_row;
  assign valid_o               = active_q;
  assign result_o.grid_address = {row_q, bank_q};
  assign result_o.segment_byte = rows_q[row_q];
  assign result_o.last_write   = last_row;

endmodule

// ===== src/seven_segment_bank_transposer.sv =====
// Seven-segment bank transposer: eight decode lanes feeding a row-serial merge stage.
// Latency: the first write appears in the cycle after start is taken.
// Throughput: one segment row written per cycle.
// busy is low during the final row, so the next bank follows without a gap.
// Reset clears the row sequencer; no write is in flight after reset.
module seven_segment_bank_transposer
  import ssbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  ssbt_in_t  cmd_i,
  output logic      busy,
  output logic      valid_o,
  output ssbt_out_t result_o
);

  logic [DigitW-1:0] digits [NumDigits];
  pattern_t          patterns [NumDigits];
  logic              load;

  assign digits[0] = cmd_i.digit_0;
  assign digits[1] = cmd_i.digit_1;
  assign digits[2] = cmd_i.digit_2;
  assign digits[3] = cmd_i.digit_3;
  assign digits[4] = cmd_i.digit_4;
  assign digits[5] = cmd_i.digit_5;
  assign digits[6] = cmd_i.digit_6;
  assign digits[7] = cmd_i.digit_7;

  assign load = start && !busy;

  for (genvar g = 0; g < NumDigits; g++) begin : g_lane
    ssbt_lane u_lane (
      .digit_i   (digits[g]),
      .point_i   (point_lit(cmd_i.bank, cmd_i.point_position, cmd_i.point_flash,
                            RowIdxW'(g))),
      .pattern_o (patterns[g])
    );
  end

  ssbt_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .bank_i    (cmd_i.bank),
    .pattern_i (patterns),
    .busy_o    (busy),
    .valid_o   (valid_o),
    .result_o  (result_o)
  );

endmodule

// ===== src/ssbt_checker.sv =====
// Port-level checker for the seven-segment bank transposer, bound to the top level.
`include "seven_segment_bank_transposer_defines.svh"

module ssbt_checker
  import ssbt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input ssbt_in_t  cmd_i,
  input logic      busy,
  input logic      valid_o,
  input ssbt_out_t result_o
);

  logic       take;
  logic       more;
  logic       ends;
  logic [3:0] addr;
  logic [2:0] row;
  logic       side;
  logic       bank_q;
  logic       first_ok;

  assign take     = start && !busy;
  assign more     = valid_o && !result_o.last_write;
  assign ends     = valid_o && result_o.last_write;
  assign addr     = result_o.grid_address;
  assign row      = addr[3:1];
  assign side     = addr[0];
  assign first_ok = valid_o && (row == 3'd0) && (side == bank_q);

  // Bank offered in the previous cycle, to match against the first row of a taken word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
    end else begin
      bank_q <= cmd_i.bank;
    end
  end

  `SSBT_ASSERT_NEXT(a_first_row, take, first_ok, "bank write did not start at row zero")
  `SSBT_ASSERT_NEXT(a_row_step, more, valid_o && (addr == $past(addr) + 4'd2), "row skipped")
  `SSBT_ASSERT_NOW(a_last_ready, ends, !busy && (row == 3'd7), "last row misplaced")
  `SSBT_ASSERT_NOW(a_idle_ready, !valid_o, !busy, "busy while no write pending")

endmodule

bind seven_segment_bank_transposer ssbt_checker u_ssbt_checker (.*);
